// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the event queue rtl
// expects signals named clock and reset in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TSEQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must hold in the cycle after a trigger
`define TSEQ_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tseq_pkg.sv -----
// shared types and codes for the time sorted event queue
// no dependencies
package tseq_pkg;

   localparam int TYPE_W = 4;
   localparam int TIME_W = 48;
   localparam int OCC_W  = 7;

   // operation codes
   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_POP       = 2'd1,
      OP_REM_FIRST = 2'd2,
      OP_REM_LAST  = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_NONE = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   // one held entry
   typedef struct packed {
      logic [TYPE_W-1:0] etype;
      logic [TIME_W-1:0] etime;
   } entry_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic              capture;
      logic              apply;
      op_type            op;
      logic [TYPE_W-1:0] req_type;
      logic [TIME_W-1:0] req_time;
   } cell_ctl_type;

endpackage

// ----- hw/rtl/tseq_cell.sv -----
// one slot of the sorted event row: holds an entry and a compare flag
// depends on tseq_pkg
module tseq_cell import tseq_pkg::*; #(
   parameter int CNT_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [CNT_W-1:0] count,
   input  entry_type    prev_entry,
   input  entry_type    next_entry,
   input  logic         prev_flag,
   input  logic         fwd_in,
   input  logic         bwd_in,
   input  entry_type    acc_in,
   output entry_type    entry_out,
   output logic         flag_out,
   output logic         fwd_out,
   output logic         bwd_out,
   output entry_type    acc_out
);

   entry_type entry_ff, entry_in;
   logic      flag_ff, flag_in;
   logic      occupied;
   logic      hit;
   logic      shift;
   logic      latest;

   assign occupied = CNT_W'(CELL_INDEX) < count;
   assign latest   = (ctl.op == OP_REM_LAST);

   // compare against the request while it is taken
   always_comb begin
      flag_in = flag_ff;
      if (ctl.capture) begin
         if (ctl.op == OP_INSERT) begin
            flag_in = occupied && (entry_ff.etime <= ctl.req_time);
         end else begin
            flag_in = occupied && ((ctl.op == OP_POP) || (entry_ff.etype == ctl.req_type));
         end
      end
   end

   // match chains in both directions, hit marks the entry to remove
   assign fwd_out = fwd_in | flag_ff;
   assign bwd_out = bwd_in | flag_ff;
   assign hit     = flag_ff && (latest ? !bwd_in : !fwd_in);
   assign acc_out = hit ? (acc_in | entry_ff) : acc_in;

   // cells at or beyond the removed entry take their right neighbour
   assign shift = latest ? (!bwd_in && (fwd_in || flag_ff)) : (fwd_in || flag_ff);

   // next slot contents
   always_comb begin
      entry_in = entry_ff;
      if (ctl.apply) begin
         if (ctl.op == OP_INSERT) begin
            if (!flag_ff) begin
               if (prev_flag) begin
                  entry_in.etype = ctl.req_type;
                  entry_in.etime = ctl.req_time;
               end else begin
                  entry_in = prev_entry;
               end
            end
         end else if (shift) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flag_ff  <= flag_in;
   end

   assign entry_out = entry_ff;
   assign flag_out  = flag_ff;

endmodule

// ----- hw/rtl/time_sorted_event_queue_core.sv -----
// time sorted event queue: a row of compare and shift cells
// a taken transfer is shifted in ST_APPLY and answered by the registered rsp_strobe
// no new operation is taken while busy: compare in the taking cycle, shift in the next
// the shift cycle carries the match chains and the result gather along the whole cell row
// reset (synchronous) empties the list and clears busy and strobe; slot contents stay as they are
// depends on tseq_pkg, tseq_cell and assert_macros.svh
`include "assert_macros.svh"

module time_sorted_event_queue_core import tseq_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [TYPE_W-1:0] req_event_type,
   input  logic [TIME_W-1:0] req_event_time,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [TYPE_W-1:0] rsp_result_type,
   output logic [TIME_W-1:0] rsp_result_time,
   output logic [OCC_W-1:0]  rsp_occupancy,
   output logic              rsp_list_empty
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   state_type         state_ff;
   op_type            op_ff;
   logic [TYPE_W-1:0] type_ff;
   logic [TIME_W-1:0] time_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              strobe_ff;
   status_type        status_ff, status_in;
   entry_type         result_ff, result_in;
   logic [OCC_W-1:0]  occ_ff;
   logic              empty_ff;

   cell_ctl_type      ctl;
   logic              full;
   logic              found;

   entry_type         cell_entry [QUEUE_DEPTH];
   logic              cell_flag  [QUEUE_DEPTH];
   logic              fwd        [QUEUE_DEPTH+1];
   logic              bwd        [QUEUE_DEPTH+1];
   entry_type         acc        [QUEUE_DEPTH+1];

   assign busy  = (state_ff == ST_APPLY);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign found = fwd[QUEUE_DEPTH];

   // broadcast control: live request while idle, held request while shifting
   always_comb begin
      ctl.capture  = (state_ff == ST_IDLE) && start;
      ctl.apply    = (state_ff == ST_APPLY) && !((op_ff == OP_INSERT) && full);
      ctl.op       = busy ? op_ff : op_type'(req_operation);
      ctl.req_type = busy ? type_ff : req_event_type;
      ctl.req_time = busy ? time_ff : req_event_time;
   end

   // chain ends
   assign fwd[0]            = 1'b0;
   assign bwd[QUEUE_DEPTH]  = 1'b0;
   assign acc[0]            = '0;

   // row of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_f;

      if (i == 0) begin : g_first
         assign prev_e = '0;
         assign prev_f = 1'b1;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_f = cell_flag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_body
         assign next_e = cell_entry[i+1];
      end

      tseq_cell #(
         .CNT_W      (CNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .prev_flag  (prev_f),
         .fwd_in     (fwd[i]),
         .bwd_in     (bwd[i+1]),
         .acc_in     (acc[i]),
         .entry_out  (cell_entry[i]),
         .flag_out   (cell_flag[i]),
         .fwd_out    (fwd[i+1]),
         .bwd_out    (bwd[i]),
         .acc_out    (acc[i+1])
      );
   end

   // response and occupancy of the operation being applied
   always_comb begin
      count_in  = count_ff;
      status_in = STAT_NONE;
      result_in = '0;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               status_in       = STAT_DONE;
               result_in.etype = type_ff;
               result_in.etime = time_ff;
               count_in        = count_ff + CNT_W'(1);
            end
         end
         default: begin
            if (found) begin
               status_in = STAT_DONE;
               result_in = acc[QUEUE_DEPTH];
               count_in  = count_ff - CNT_W'(1);
            end
         end
      endcase
   end

   // control sequence and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= op_type'(req_operation);
                  type_ff  <= req_event_type;
                  time_ff  <= req_event_time;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               count_ff  <= count_in;
               strobe_ff <= 1'b1;
               status_ff <= status_in;
               result_ff <= result_in;
               occ_ff    <= OCC_W'(count_in);
               empty_ff  <= (count_in == '0);
               state_ff  <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_type = result_ff.etype;
   assign rsp_result_time = result_ff.etime;
   assign rsp_occupancy   = occ_ff;
   assign rsp_list_empty  = empty_ff;

   // checks
   `TSEQ_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "entry count beyond depth")
   `TSEQ_ASSERT_NEXT(a_apply_once, state_ff == ST_APPLY, state_ff == ST_IDLE && strobe_ff, "shift phase did not end with a response")
   `TSEQ_ASSERT(a_strobe_source, strobe_ff |-> $past(state_ff == ST_APPLY), "response without a shift phase")
   `TSEQ_ASSERT(a_insert_grows, (strobe_ff && op_ff == OP_INSERT && status_ff == STAT_DONE) |-> count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the list")
   `TSEQ_ASSERT(a_miss_keeps, (strobe_ff && status_ff != STAT_DONE) |-> count_ff == $past(count_ff), "failed operation changed the count")

endmodule
